### rtl/eph_pkg.sv
// Shared types, codes and constants of the edge-pair hash table.
package eph_pkg;

  localparam int unsigned CapacityDef = 1024;

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StInserted = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [63:0] HashMultA = 64'ha0761d65;
  localparam logic [63:0] HashSeed  = 64'd2685821657736338717 + 64'heb44accb;
  localparam logic [63:0] HashMultB = HashMultA ^ 64'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [31:0] value_first;
    logic [31:0] value_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] found_first;
    logic [31:0] found_second;
    logic [10:0] occupied;
  } out_item_t;

  typedef struct packed {
    logic hv;
    logic key;
    logic val;
  } wr_en_t;

endpackage

### rtl/eph_hash.sv
// Multi-cycle key-pair hash: shared 32x32 multiplier for the mix and the home-slot reduction.
module eph_hash #(
  parameter int unsigned CAPACITY = eph_pkg::CapacityDef,
  localparam int unsigned SW = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   key_first_i,
  input  logic [31:0]   key_second_i,
  output logic          done_o,
  output logic [30:0]   hash_o,
  output logic [SW-1:0] home_o
);
  import eph_pkg::*;

  localparam logic [3:0] PhIdle = 4'd0;
  localparam logic [3:0] PhM0   = 4'd1;
  localparam logic [3:0] PhM1   = 4'd2;
  localparam logic [3:0] PhFold = 4'd3;
  localparam logic [3:0] PhM2   = 4'd4;
  localparam logic [3:0] PhM3   = 4'd5;
  localparam logic [3:0] PhFin  = 4'd6;
  localparam logic [3:0] PhQuot = 4'd7;
  localparam logic [3:0] PhProd = 4'd8;
  localparam logic [3:0] PhCorr = 4'd9;

  // The quotient estimate from this reciprocal is low by at most one.
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(CAPACITY));
  localparam logic [31:0] CapW  = 32'(CAPACITY);

  logic [3:0]  phase_q, phase_d;
  logic [31:0] k0_q, k1_q;
  logic [63:0] acc_q, t_q, x, s, fin;
  logic [31:0] mul_a, mul_b, y;
  logic [63:0] prod;
  logic [30:0] hash_q;
  logic [31:0] quo_q, rem_q, rem_fix;

  assign x = HashSeed ^ {32'b0, k0_q};
  assign y = k1_q ^ HashMultA[31:0];
  assign s = acc_q - (acc_q >> 32);
  assign fin = acc_q - (acc_q >> 32);

  always_comb begin
    case (phase_q)
      PhM0: begin mul_a = x[31:0];   mul_b = y; end
      PhM1: begin mul_a = x[63:32];  mul_b = y; end
      PhM2: begin mul_a = t_q[31:0]; mul_b = HashMultB[31:0]; end
      PhM3: begin mul_a = t_q[63:32]; mul_b = HashMultB[31:0]; end
      PhQuot: begin mul_a = {1'b0, hash_q}; mul_b = Recip; end
      PhProd: begin mul_a = quo_q; mul_b = CapW; end
      default: begin mul_a = 32'b0; mul_b = 32'b0; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  assign rem_fix = (rem_q >= CapW) ? rem_q - CapW : rem_q;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhIdle: if (start_i) phase_d = PhM0;
      PhM0:   phase_d = PhM1;
      PhM1:   phase_d = PhFold;
      PhFold: phase_d = PhM2;
      PhM2:   phase_d = PhM3;
      PhM3:   phase_d = PhFin;
      PhFin:  phase_d = PhQuot;
      PhQuot: phase_d = PhProd;
      PhProd: phase_d = PhCorr;
      PhCorr: phase_d = PhIdle;
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PhIdle: begin
        k0_q <= key_first_i;
        k1_q <= key_second_i;
      end
      PhM0: acc_q <= prod;
      PhM1: acc_q <= acc_q + {prod[31:0], 32'b0};
      PhFold: t_q <= s ^ (s << 16);
      PhM2: acc_q <= prod;
      PhM3: acc_q <= acc_q + {prod[31:0], 32'b0};
      PhFin: hash_q <= fin[30:0];
      PhQuot: quo_q <= prod[63:32];
      PhProd: rem_q <= {1'b0, hash_q} - prod[31:0];
      default: acc_q <= acc_q;
    endcase
  end

  assign done_o = (phase_q == PhCorr);
  assign hash_o = hash_q;
  assign home_o = SW'(rem_fix);
endmodule

### rtl/eph_mem.sv
// Slot storage: tag/valid, key and value arrays with one write and one registered read per cycle.
module eph_mem #(
  parameter int unsigned CAPACITY = eph_pkg::CapacityDef,
  localparam int unsigned SW = $clog2(CAPACITY)
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [SW-1:0]   rd_addr_i,
  output logic [31:0]     rd_hv_o,
  output logic [63:0]     rd_key_o,
  output logic [63:0]     rd_val_o,
  input  eph_pkg::wr_en_t wr_en_i,
  input  logic [SW-1:0]   wr_addr_i,
  input  logic [31:0]     wr_hv_i,
  input  logic [63:0]     wr_key_i,
  input  logic [63:0]     wr_val_i
);
  import eph_pkg::*;

  logic [31:0] hv_mem  [CAPACITY];
  logic [63:0] key_mem [CAPACITY];
  logic [63:0] val_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_en_i.hv)  hv_mem[wr_addr_i]  <= wr_hv_i;
    if (wr_en_i.key) key_mem[wr_addr_i] <= wr_key_i;
    if (wr_en_i.val) val_mem[wr_addr_i] <= wr_val_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_hv_o  <= hv_mem[rd_addr_i];
      rd_key_o <= key_mem[rd_addr_i];
      rd_val_o <= val_mem[rd_addr_i];
    end
  end
endmodule

### rtl/edge_pair_hash_table_top.sv
// Edge-pair hash table top level: request sequencer around the hash unit and slot memory.
// Sequence: hashing and home-slot reduction, then one slot read per cycle along the probe
// path, a drain of the last read, and a finishing step that waits for a free result register.
// Requests: one at a time; the next input transfer can follow in the cycle after the result
// is loaded.
// Reset: asynchronous, active low; a clearing pass then empties every slot.
module edge_pair_hash_table_top #(
  parameter int unsigned CAPACITY = eph_pkg::CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  eph_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output eph_pkg::out_item_t out_data_o
);
  import eph_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]    state_q, state_d;
  in_item_t      req_q;
  logic [30:0]   hash_q;
  logic [SW-1:0] idx_q, idx_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [SW-1:0] pend_addr_q;
  logic          hit_q, hit_d;
  logic [SW-1:0] where_q, where_d;
  logic          empty_seen_q, empty_seen_d;
  logic [SW-1:0] empty_q, empty_d;
  logic [63:0]   fnd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q;
  out_item_t     out_q, out_d;
  logic          out_load;

  logic          hash_start, hash_done;
  logic [30:0]   hash_val;
  logic [SW-1:0] hash_home;

  logic          rd_en;
  logic [31:0]   rd_hv;
  logic [63:0]   rd_key, rd_val;
  wr_en_t        wr_en;
  logic [SW-1:0] wr_addr;
  logic [31:0]   wr_hv;
  logic          slot_match, issue;
  logic [SW-1:0] idx_next;

  eph_hash #(.CAPACITY(CAPACITY)) u_hash (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (hash_start),
    .key_first_i  (in_data_i.key_first),
    .key_second_i (in_data_i.key_second),
    .done_o       (hash_done),
    .hash_o       (hash_val),
    .home_o       (hash_home)
  );

  eph_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_hv_o   (rd_hv),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_hv_i   (wr_hv),
    .wr_key_i  ({req_q.key_second, req_q.key_first}),
    .wr_val_i  ({req_q.value_second, req_q.value_first})
  );

  // A request is taken only from the idle state; the result register is separate,
  // so a new request may start while the previous result still waits.
  assign in_stall_o = (state_q != SIdle);
  assign hash_start = in_valid_i && (state_q == SIdle);

  // A stored slot matches when its valid bit and hash agree and the full key is equal.
  assign slot_match = pend_q && (rd_hv == {1'b1, hash_q}) &&
                      (rd_key == {req_q.key_second, req_q.key_first});
  assign idx_next = (idx_q == SW'(CAPACITY - 1)) ? '0 : idx_q + SW'(1);
  assign issue = (state_q == SScan) && (iss_q != CW'(CAPACITY)) && !slot_match;
  assign rd_en = issue;

  // The finishing step needs the result register free.
  assign out_load = (state_q == SDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    iss_d = iss_q;
    pend_d = 1'b0;
    hit_d = hit_q;
    where_d = where_q;
    empty_seen_d = empty_seen_q;
    empty_d = empty_q;
    cnt_d = cnt_q;
    wr_en = '0;
    wr_addr = idx_q;
    wr_hv = 32'b0;
    out_d = out_q;

    case (state_q)
      SClear: begin
        // Sweep every slot to empty, one per cycle.
        wr_en.hv = 1'b1;
        idx_d = idx_next;
        if (idx_q == SW'(CAPACITY - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) state_d = SHash;
      end
      SHash: begin
        if (hash_done) begin
          idx_d = hash_home;
          iss_d = '0;
          hit_d = 1'b0;
          empty_seen_d = 1'b0;
          // An unused operation code skips the probe entirely.
          if (req_q.operation == OpLookup || req_q.operation == OpInsert ||
              req_q.operation == OpRemove) begin
            state_d = SScan;
          end else begin
            state_d = SDone;
          end
        end
      end
      SScan: begin
        if (issue) begin
          idx_d = idx_next;
          iss_d = iss_q + CW'(1);
          pend_d = 1'b1;
        end
        if (slot_match) begin
          hit_d = 1'b1;
          where_d = pend_addr_q;
          state_d = SDone;
        end else begin
          if (pend_q && !rd_hv[31] && !empty_seen_q) begin
            empty_seen_d = 1'b1;
            empty_d = pend_addr_q;
          end
          if (!pend_q && (iss_q == CW'(CAPACITY))) state_d = SDone;
        end
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
          out_d.status = StNotFound;
          out_d.slot = 10'b0;
          out_d.found_first = 32'b0;
          out_d.found_second = 32'b0;
          case (req_q.operation)
            OpLookup: begin
              if (hit_q) begin
                out_d.status = StFound;
                out_d.slot = 10'(where_q);
                out_d.found_first = fnd_q[31:0];
                out_d.found_second = fnd_q[63:32];
              end
            end
            OpInsert: begin
              if (hit_q) begin
                wr_en.val = 1'b1;
                wr_addr = where_q;
                out_d.status = StFound;
                out_d.slot = 10'(where_q);
              end else if (cnt_q >= CW'(CAPACITY) || !empty_seen_q) begin
                out_d.status = StFull;
              end else begin
                wr_en = '{hv: 1'b1, key: 1'b1, val: 1'b1};
                wr_addr = empty_q;
                wr_hv = {1'b1, hash_q};
                cnt_d = cnt_q + CW'(1);
                out_d.status = StInserted;
                out_d.slot = 10'(empty_q);
              end
            end
            OpRemove: begin
              if (hit_q) begin
                wr_en.hv = 1'b1;
                wr_addr = where_q;
                if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
                out_d.status = StFound;
                out_d.slot = 10'(where_q);
              end
            end
            default: out_d.status = StNotFound;
          endcase
          out_d.occupied = 11'(cnt_d);
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      idx_q <= '0;
      iss_q <= '0;
      pend_q <= 1'b0;
      hit_q <= 1'b0;
      empty_seen_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      iss_q <= iss_d;
      pend_q <= pend_d;
      hit_q <= hit_d;
      empty_seen_q <= empty_seen_d;
      cnt_q <= cnt_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hash_start) req_q <= in_data_i;
    if (hash_done) hash_q <= hash_val;
    pend_addr_q <= idx_q;
    where_q <= where_d;
    empty_q <= empty_d;
    if (slot_match) fnd_q <= rd_val;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
